[rtl/core/tcce_pkg.sv]
// shared types and constants for the text console cursor engine
package tcce_pkg;

  // field widths of the transaction ports
  localparam int MODE_W    = 1;
  localparam int CHAR_W    = 8;
  localparam int INDEX_W   = 11;
  localparam int POS_OUT_W = 11;
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;
  localparam int CELL_W    = 16;
  localparam int ATTR_W    = 8;

  // configuration port
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_TEXT_ATTRIBUTE = 2'd0;
  localparam logic [ATTR_W-1:0]  ATTR_RESET          = 8'h07;

  // item modes
  localparam logic [MODE_W-1:0] MODE_PUT  = 1'b0;
  localparam logic [MODE_W-1:0] MODE_READ = 1'b1;

  // control codes
  localparam logic [CHAR_W-1:0] CH_BEL   = 8'h07;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // grey space written by the clearing pass
  localparam logic [CELL_W-1:0] CLEAR_CELL = 16'h0720;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_TABPOS,
    ST_CRLINE,
    ST_LINE,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_FILL,
    ST_RDWAIT,
    ST_DONE
  } state_t;

  // one finished result
  typedef struct packed {
    logic [POS_OUT_W-1:0] cursor_position;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_column;
    logic [CELL_W-1:0]    cell_entry;
    logic                 scrolled;
  } result_t;

endpackage

[rtl/core/tcce_alu.sv]
// shared add/subtract unit with a limit compare
module tcce_alu #(
  parameter int W = 11
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  input  logic [W-1:0] lim,
  output logic [W-1:0] y,
  output logic         ge
);

  // sum or difference, then compare against the limit
  assign y  = sub ? (a - b) : (a + b);
  assign ge = (y >= lim);

endmodule

[rtl/core/tcce_screen_mem.sv]
// screen cell memory, one write port and one registered read port
module tcce_screen_mem #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [tcce_pkg::CELL_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [tcce_pkg::CELL_W-1:0] rdata
);
  import tcce_pkg::*;

  logic [CELL_W-1:0] cell_mem_r [DEPTH];
  logic [CELL_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      cell_mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= cell_mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/tcce_ctrl.sv]
// sequencer: cursor update, cell writes, scroll copy and clearing pass
module tcce_ctrl #(
  parameter int COLS = 80,
  parameter int ROWS = 25,
  parameter int TAB  = 8,
  localparam int CELLS = COLS * ROWS,
  localparam int AW    = $clog2(CELLS),
  localparam int W     = $clog2(CELLS + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input transaction
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tcce_pkg::MODE_W-1:0]  in_mode,
  input  logic [tcce_pkg::CHAR_W-1:0]  in_char_code,
  input  logic [tcce_pkg::INDEX_W-1:0] in_cell_index,
  input  logic [tcce_pkg::ATTR_W-1:0]  text_attribute,
  // shared arithmetic unit
  output logic [W-1:0]                 alu_a,
  output logic [W-1:0]                 alu_b,
  output logic                         alu_sub,
  output logic [W-1:0]                 alu_lim,
  input  logic [W-1:0]                 alu_y,
  input  logic                         alu_ge,
  // screen memory
  output logic                         mem_we,
  output logic [AW-1:0]                mem_waddr,
  output logic [tcce_pkg::CELL_W-1:0]  mem_wdata,
  output logic                         mem_re,
  output logic [AW-1:0]                mem_raddr,
  input  logic [tcce_pkg::CELL_W-1:0]  mem_rdata,
  // result handoff
  output logic                         res_valid,
  input  logic                         res_free,
  output tcce_pkg::result_t            res
);
  import tcce_pkg::*;

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);
  localparam int PW = (TAB > 1) ? $clog2(TAB) : 1;
  localparam int LAST_PH = (COLS - 1) % TAB;

  state_t state_r, state_nxt;
  logic [RW-1:0]      row_r, row_nxt;
  logic [CW-1:0]      col_r, col_nxt;
  logic [PW-1:0]      phase_r, phase_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [AW-1:0]      cnt_r, cnt_nxt;
  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [CHAR_W-1:0]  char_r, char_nxt;
  logic [INDEX_W-1:0] idx_r, idx_nxt;
  logic [CELL_W-1:0]  entry_r, entry_nxt;
  logic               scrolled_r, scrolled_nxt;

  logic          idx_in_range;
  logic          col_last;
  logic          row_last;
  logic [PW-1:0] phase_inc;
  logic [PW-1:0] phase_dec;
  logic [W-1:0]  tab_delta;

  // status decode
  assign idx_in_range = (32'(idx_r) < 32'(CELLS));
  assign col_last     = (col_r == CW'(COLS - 1));
  assign row_last     = (row_r == RW'(ROWS - 1));
  assign phase_inc    = (phase_r == PW'(TAB - 1)) ? '0 : (phase_r + PW'(1));
  assign phase_dec    = (phase_r == '0) ? PW'(TAB - 1) : (phase_r - PW'(1));
  assign tab_delta    = W'(TAB) - W'(phase_r);

  // state register and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      row_r   <= '0;
      col_r   <= '0;
      phase_r <= '0;
      pos_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // item payload and result bits
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    char_r     <= char_nxt;
    idx_r      <= idx_nxt;
    entry_r    <= entry_nxt;
    scrolled_r <= scrolled_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (alu_ge) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (mode_r == MODE_READ) begin
          state_nxt = idx_in_range ? ST_RDWAIT : ST_DONE;
        end else begin
          unique case (char_r)
            CH_BEL, CH_BS, CH_CR: state_nxt = ST_DONE;
            CH_LF:                state_nxt = ST_LINE;
            CH_TAB:               state_nxt = alu_ge ? ST_CRLINE : ST_TABPOS;
            default:              state_nxt = col_last ? ST_CRLINE : ST_DONE;
          endcase
        end
      end
      ST_TABPOS: state_nxt = ST_DONE;
      ST_CRLINE: state_nxt = ST_LINE;
      ST_LINE:   state_nxt = row_last ? ST_SCR_RD : ST_DONE;
      ST_SCR_RD: state_nxt = ST_SCR_WR;
      ST_SCR_WR: state_nxt = alu_ge ? ST_FILL : ST_SCR_RD;
      ST_FILL: begin
        if (alu_ge) state_nxt = ST_DONE;
      end
      ST_RDWAIT: state_nxt = ST_DONE;
      ST_DONE: begin
        if (res_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath control per state
  always_comb begin
    row_nxt      = row_r;
    col_nxt      = col_r;
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    cnt_nxt      = cnt_r;
    mode_nxt     = mode_r;
    char_nxt     = char_r;
    idx_nxt      = idx_r;
    entry_nxt    = entry_r;
    scrolled_nxt = scrolled_r;
    alu_a        = W'(pos_r);
    alu_b        = '0;
    alu_sub      = 1'b0;
    alu_lim      = W'(CELLS);
    mem_we       = 1'b0;
    mem_waddr    = cnt_r;
    mem_wdata    = CLEAR_CELL;
    mem_re       = 1'b0;
    mem_raddr    = AW'(alu_y);
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    unique case (state_r)
      // sweep the memory with grey spaces
      ST_CLEAR: begin
        alu_a   = W'(cnt_r);
        alu_b   = W'(1);
        mem_we  = 1'b1;
        cnt_nxt = AW'(alu_y);
      end
      // take a new transaction
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mode_nxt     = in_mode;
          char_nxt     = in_char_code;
          idx_nxt      = in_cell_index;
          entry_nxt    = '0;
          scrolled_nxt = 1'b0;
        end
      end
      // first step of every item
      ST_EXEC: begin
        if (mode_r == MODE_READ) begin
          if (idx_in_range) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(idx_r);
          end
        end else begin
          unique case (char_r)
            CH_BEL: begin
            end
            CH_BS: begin
              alu_b   = W'(1);
              alu_sub = 1'b1;
              if (col_r != '0) begin
                pos_nxt   = AW'(alu_y);
                col_nxt   = col_r - CW'(1);
                phase_nxt = phase_dec;
              end else if (row_r != '0) begin
                pos_nxt   = AW'(alu_y);
                col_nxt   = CW'(COLS - 1);
                row_nxt   = row_r - RW'(1);
                phase_nxt = PW'(LAST_PH);
              end
            end
            CH_LF, CH_CR: begin
              alu_b     = W'(col_r);
              alu_sub   = 1'b1;
              pos_nxt   = AW'(alu_y);
              col_nxt   = '0;
              phase_nxt = '0;
            end
            CH_TAB: begin
              alu_a   = W'(col_r);
              alu_b   = tab_delta;
              alu_lim = W'(COLS);
              if (!alu_ge) col_nxt = CW'(alu_y);
            end
            default: begin
              mem_we    = 1'b1;
              mem_waddr = pos_r;
              mem_wdata = {text_attribute, char_r};
              alu_b     = W'(1);
              if (!col_last) begin
                pos_nxt   = AW'(alu_y);
                col_nxt   = col_r + CW'(1);
                phase_nxt = phase_inc;
              end
            end
          endcase
        end
      end
      // tab inside the row: move the linear position
      ST_TABPOS: begin
        alu_b     = tab_delta;
        pos_nxt   = AW'(alu_y);
        phase_nxt = '0;
      end
      // back to column 0 before a line feed
      ST_CRLINE: begin
        alu_b     = W'(col_r);
        alu_sub   = 1'b1;
        pos_nxt   = AW'(alu_y);
        col_nxt   = '0;
        phase_nxt = '0;
      end
      // down one row, or start a scroll at the bottom
      ST_LINE: begin
        alu_b = W'(COLS);
        if (row_last) begin
          scrolled_nxt = 1'b1;
          cnt_nxt      = '0;
        end else begin
          pos_nxt = AW'(alu_y);
          row_nxt = row_r + RW'(1);
        end
      end
      // scroll copy: read the cell one row below
      ST_SCR_RD: begin
        alu_a  = W'(cnt_r);
        alu_b  = W'(COLS);
        mem_re = 1'b1;
      end
      // scroll copy: write it one row up
      ST_SCR_WR: begin
        alu_a     = W'(cnt_r);
        alu_b     = W'(1);
        alu_lim   = W'(CELLS - COLS);
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        cnt_nxt   = AW'(alu_y);
      end
      // blank the last row
      ST_FILL: begin
        alu_a     = W'(cnt_r);
        alu_b     = W'(1);
        mem_we    = 1'b1;
        mem_wdata = {text_attribute, CH_SPACE};
        cnt_nxt   = AW'(alu_y);
      end
      ST_RDWAIT: begin
        entry_nxt = mem_rdata;
      end
      ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // result fields at the port widths
  assign res.cursor_position = POS_OUT_W'(pos_r);
  assign res.cursor_row      = ROW_OUT_W'(row_r);
  assign res.cursor_column   = COL_OUT_W'(col_r);
  assign res.cell_entry      = entry_r;
  assign res.scrolled        = scrolled_r;

endmodule

[rtl/core/text_console_cursor_engine.sv]
// top level of the text console cursor engine
// sequence: each item passes ST_EXEC, then waits in ST_DONE until the result is stored; a tab in
//   its row adds ST_TABPOS, a line feed ST_LINE, an in-range read ST_RDWAIT, a wrap ST_CRLINE and
//   ST_LINE; a scroll adds ST_SCR_RD/ST_SCR_WR copy pairs and an ST_FILL pass over the last row
// flow: one item at a time; the next is accepted in ST_IDLE once the result is stored
// reset: synchronous active low; a clearing pass then writes every cell, with input not ready
module text_console_cursor_engine #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25,
  parameter int TAB_STOP       = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tcce_pkg::PADDR_W-1:0]    paddr,
  input  logic [tcce_pkg::PDATA_W-1:0]    pwdata,
  output logic [tcce_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tcce_pkg::MODE_W-1:0]     in_mode,
  input  logic [tcce_pkg::CHAR_W-1:0]     in_char_code,
  input  logic [tcce_pkg::INDEX_W-1:0]    in_cell_index,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tcce_pkg::POS_OUT_W-1:0]  out_cursor_position,
  output logic [tcce_pkg::ROW_OUT_W-1:0]  out_cursor_row,
  output logic [tcce_pkg::COL_OUT_W-1:0]  out_cursor_column,
  output logic [tcce_pkg::CELL_W-1:0]     out_cell_entry,
  output logic                            out_scrolled
);
  import tcce_pkg::*;

  localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int W     = $clog2(CELLS + 1);

  logic [ATTR_W-1:0] attr_r;
  logic              attr_wr;

  logic [W-1:0]  alu_a, alu_b, alu_lim, alu_y;
  logic          alu_sub, alu_ge;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata;

  logic    res_valid, res_free;
  result_t res;
  result_t out_res_r;
  logic    out_valid_r;

  // attribute register write and read back
  assign pready  = 1'b1;
  assign attr_wr = psel && penable && pwrite && (paddr == ADDR_TEXT_ATTRIBUTE);
  assign prdata  = (paddr == ADDR_TEXT_ATTRIBUTE) ? PDATA_W'(attr_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (attr_wr) begin
      attr_r <= pwdata[ATTR_W-1:0];
    end
  end

  // sequencer
  tcce_ctrl #(
    .COLS (SCREEN_COLUMNS),
    .ROWS (SCREEN_ROWS),
    .TAB  (TAB_STOP)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_char_code   (in_char_code),
    .in_cell_index  (in_cell_index),
    .text_attribute (attr_r),
    .alu_a          (alu_a),
    .alu_b          (alu_b),
    .alu_sub        (alu_sub),
    .alu_lim        (alu_lim),
    .alu_y          (alu_y),
    .alu_ge         (alu_ge),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata),
    .res_valid      (res_valid),
    .res_free       (res_free),
    .res            (res)
  );

  // shared adder and compare
  tcce_alu #(
    .W (W)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .lim (alu_lim),
    .y   (alu_y),
    .ge  (alu_ge)
  );

  // screen cells
  tcce_screen_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register
  assign res_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_free) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_position = out_res_r.cursor_position;
  assign out_cursor_row      = out_res_r.cursor_row;
  assign out_cursor_column   = out_res_r.cursor_column;
  assign out_cell_entry      = out_res_r.cell_entry;
  assign out_scrolled        = out_res_r.scrolled;

endmodule
